>>> design/tdisp_pkg.sv
// Package for the tile work dispatcher: action codes, sequencer states,
// table write-control struct and default sizes. No dependencies.
`timescale 1ns / 1ps

package tdisp_pkg;

  localparam int MAX_TILES_DEF = 64;
  localparam int PASS_BITS_DEF = 16;

  localparam int ACT_W   = 3;
  localparam int INDEX_W = 7;
  localparam int COUNT_W = 7;
  localparam int PASS_W  = 16;

  localparam logic [COUNT_W-1:0] TILE_COUNT_RESET = 7'd64;
  localparam logic [INDEX_W-1:0] NO_TILE          = 7'h7F;

  localparam logic [ACT_W-1:0] ACT_REQUEST    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DISABLE    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RESERVE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ENABLE_ALL = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic en_we;
    logic en_wdata;
    logic pass_we;
  } tbl_ctl_t;

endpackage

>>> design/tile_work_dispatcher.sv
// Tile work dispatcher top level: sequencer, shared compare/update datapath.
// Uses tdisp_pkg and tdisp_table.
// Enable-all and clear add a table sweep over all MAX_TILES entries. One item at a time;
// the table scan (one entry per cycle through the read port) sets the rate.
// Reset: a pass over all MAX_TILES table entries that enables every tile and clears
// the pass words, in_ready low meanwhile.
`timescale 1ns / 1ps

module tile_work_dispatcher #(
  parameter int MAX_TILES = tdisp_pkg::MAX_TILES_DEF,
  parameter int PASS_BITS = tdisp_pkg::PASS_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tdisp_pkg::COUNT_W-1:0]        cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tdisp_pkg::ACT_W-1:0]          action,
  input  logic signed [tdisp_pkg::INDEX_W-1:0] tile_index,
  input  logic [tdisp_pkg::PASS_W-1:0]         pass_number,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tdisp_pkg::INDEX_W-1:0] next_tile,
  output logic                                 all_done
);

  localparam int IDX_W = $clog2(MAX_TILES);
  localparam int CNT_W = $clog2(MAX_TILES + 1);
  localparam int CMP_W = (CNT_W > tdisp_pkg::INDEX_W) ? CNT_W : tdisp_pkg::INDEX_W;

  tdisp_pkg::state_t state, state_next;

  logic [tdisp_pkg::COUNT_W-1:0] tile_count;
  logic [CNT_W-1:0]              cnt;
  logic [IDX_W-1:0]              proc_i;
  logic                          proc_valid;
  logic                          found;
  logic [tdisp_pkg::INDEX_W-1:0] found_idx;
  logic                          all_acc;

  logic [tdisp_pkg::ACT_W-1:0]   act;
  logic                          idx_neg;
  logic [CMP_W-1:0]              idx_cmp;
  logic [PASS_BITS-1:0]          pass;

  logic [CMP_W-1:0]              tc_cmp;
  logic [CMP_W-1:0]              max_cmp;
  logic [CMP_W-1:0]              n_cmp;
  logic [CNT_W-1:0]              n;
  logic                          issue;
  logic                          sweep_last;
  logic                          accept;
  logic                          out_load;

  logic [PASS_BITS+tdisp_pkg::PASS_W-1:0] pass_ext;

  tdisp_pkg::tbl_ctl_t           ctl;
  logic [IDX_W-1:0]              wr_addr;
  logic [2*PASS_BITS-1:0]        pass_wdata;
  logic                          en_rdata;
  logic [2*PASS_BITS-1:0]        pass_rdata;

  logic [PASS_BITS-1:0]          res_rd, done_rd, res_new, done_new;
  logic [CMP_W-1:0]              proc_cmp;
  logic                          is_tgt, after_start, cand, done_low;

  tdisp_table #(
    .MAX_TILES (MAX_TILES),
    .PASS_BITS (PASS_BITS)
  ) u_table (
    .clk        (clk),
    .ctl        (ctl),
    .rd_addr    (cnt[IDX_W-1:0]),
    .wr_addr    (wr_addr),
    .pass_wdata (pass_wdata),
    .en_rdata   (en_rdata),
    .pass_rdata (pass_rdata)
  );

  // tiles in use = min(tile_count, MAX_TILES)
  assign tc_cmp     = CMP_W'(tile_count);
  assign max_cmp    = CMP_W'(MAX_TILES);
  assign n_cmp      = (tc_cmp < max_cmp) ? tc_cmp : max_cmp;
  assign n          = n_cmp[CNT_W-1:0];
  assign issue      = (cnt < n);
  assign sweep_last = (cnt == CNT_W'(MAX_TILES - 1));
  assign accept     = in_valid && in_ready;
  assign pass_ext   = {{PASS_BITS{1'b0}}, pass_number};

  // entry update for the tile coming out of the read port
  always_comb begin
    res_rd      = pass_rdata[2*PASS_BITS-1:PASS_BITS];
    done_rd     = pass_rdata[PASS_BITS-1:0];
    proc_cmp    = CMP_W'(proc_i);
    is_tgt      = !idx_neg && (proc_cmp == idx_cmp);
    after_start = idx_neg || (proc_cmp > idx_cmp);
    cand        = (act == tdisp_pkg::ACT_REQUEST) && !found && en_rdata &&
                  (res_rd < pass) && after_start;
    done_new    = ((act == tdisp_pkg::ACT_REQUEST) && is_tgt) ? pass : done_rd;
    if (cand) begin
      res_new = pass;
    end else if ((act == tdisp_pkg::ACT_RESERVE) && is_tgt) begin
      res_new = PASS_BITS'(1);
    end else begin
      res_new = res_rd;
    end
    done_low = (done_new < pass);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tdisp_pkg::ST_INIT: begin
        if (sweep_last) state_next = tdisp_pkg::ST_IDLE;
      end
      tdisp_pkg::ST_IDLE: begin
        if (accept) begin
          if ((action == tdisp_pkg::ACT_ENABLE_ALL) || (action == tdisp_pkg::ACT_CLEAR)) begin
            state_next = tdisp_pkg::ST_SWEEP;
          end else begin
            state_next = tdisp_pkg::ST_SCAN;
          end
        end
      end
      tdisp_pkg::ST_SWEEP: begin
        if (sweep_last) state_next = tdisp_pkg::ST_SCAN;
      end
      tdisp_pkg::ST_SCAN: begin
        if (!issue && !proc_valid) state_next = tdisp_pkg::ST_FINISH;
      end
      tdisp_pkg::ST_FINISH: begin
        if (out_load) state_next = tdisp_pkg::ST_IDLE;
      end
      default: state_next = tdisp_pkg::ST_INIT;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl        = '0;
    wr_addr    = proc_i;
    pass_wdata = {res_new, done_new};
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      tdisp_pkg::ST_INIT: begin
        ctl.en_we    = 1'b1;
        ctl.en_wdata = 1'b1;
        ctl.pass_we  = 1'b1;
        pass_wdata   = '0;
        wr_addr      = cnt[IDX_W-1:0];
      end
      tdisp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      tdisp_pkg::ST_SWEEP: begin
        wr_addr    = cnt[IDX_W-1:0];
        pass_wdata = '0;
        if (act == tdisp_pkg::ACT_ENABLE_ALL) begin
          ctl.en_we    = 1'b1;
          ctl.en_wdata = 1'b1;
        end else begin
          ctl.pass_we = 1'b1;
        end
      end
      tdisp_pkg::ST_SCAN: begin
        ctl.rd_en = issue;
        if (proc_valid) begin
          ctl.pass_we  = 1'b1;
          ctl.en_we    = (act == tdisp_pkg::ACT_DISABLE) && is_tgt;
          ctl.en_wdata = 1'b0;
        end
      end
      tdisp_pkg::ST_FINISH: begin
        out_load = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tdisp_pkg::ST_INIT;
      tile_count <= tdisp_pkg::TILE_COUNT_RESET;
      cnt        <= '0;
      proc_valid <= 1'b0;
      found      <= 1'b0;
      all_acc    <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      proc_valid <= ctl.rd_en;
      if (cfg_we) tile_count <= cfg_wdata;
      case (state)
        tdisp_pkg::ST_INIT, tdisp_pkg::ST_SWEEP: begin
          cnt <= sweep_last ? '0 : cnt + CNT_W'(1);
        end
        tdisp_pkg::ST_IDLE: begin
          if (accept) begin
            cnt     <= '0;
            found   <= 1'b0;
            all_acc <= 1'b1;
          end
        end
        tdisp_pkg::ST_SCAN: begin
          if (issue) cnt <= cnt + CNT_W'(1);
          if (proc_valid) begin
            if (cand) found <= 1'b1;
            if (done_low) all_acc <= 1'b0;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    proc_i <= cnt[IDX_W-1:0];
    if (accept) begin
      act     <= action;
      idx_neg <= tile_index[tdisp_pkg::INDEX_W-1];
      idx_cmp <= CMP_W'(tile_index[tdisp_pkg::INDEX_W-2:0]);
      pass    <= pass_ext[PASS_BITS-1:0];
    end
    if ((state == tdisp_pkg::ST_SCAN) && proc_valid && cand) begin
      found_idx <= proc_cmp[tdisp_pkg::INDEX_W-1:0];
    end
    if (out_load) begin
      next_tile <= found ? found_idx : tdisp_pkg::NO_TILE;
      all_done  <= all_acc;
    end
  end

  a_proc_in_range: assert property (@(posedge clk) disable iff (rst)
    proc_valid |-> (CNT_W'(proc_i) < n))
    else $error("processed tile beyond tiles in use");

  a_found_only_request: assert property (@(posedge clk) disable iff (rst)
    (state == tdisp_pkg::ST_FINISH && found) |-> (act == tdisp_pkg::ACT_REQUEST))
    else $error("tile reserved by a non-request action");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken while an item is in work");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == tdisp_pkg::ST_IDLE))
    else $error("result not presented after finish");

  a_no_read_write_clash: assert property (@(posedge clk) disable iff (rst)
    (ctl.rd_en && ctl.pass_we) |-> (cnt[IDX_W-1:0] != wr_addr))
    else $error("table read and write at the same entry");

endmodule

>>> design/tdisp_table.sv
// Tile table storage: enable bits and {reserved, done} pass words.
// One write and one registered read per cycle on each array. Uses tdisp_pkg.
`timescale 1ns / 1ps

module tdisp_table #(
  parameter int MAX_TILES = tdisp_pkg::MAX_TILES_DEF,
  parameter int PASS_BITS = tdisp_pkg::PASS_BITS_DEF
) (
  input  logic                         clk,
  input  tdisp_pkg::tbl_ctl_t          ctl,
  input  logic [$clog2(MAX_TILES)-1:0] rd_addr,
  input  logic [$clog2(MAX_TILES)-1:0] wr_addr,
  input  logic [2*PASS_BITS-1:0]       pass_wdata,
  output logic                         en_rdata,
  output logic [2*PASS_BITS-1:0]       pass_rdata
);

  logic                   en_mem   [MAX_TILES];
  logic [2*PASS_BITS-1:0] pass_mem [MAX_TILES];

  always_ff @(posedge clk) begin
    if (ctl.en_we) begin
      en_mem[wr_addr] <= ctl.en_wdata;
    end
    if (ctl.pass_we) begin
      pass_mem[wr_addr] <= pass_wdata;
    end
    if (ctl.rd_en) begin
      en_rdata   <= en_mem[rd_addr];
      pass_rdata <= pass_mem[rd_addr];
    end
  end

endmodule

>>> dv/tile_work_dispatcher_tb.sv
// Self-checking testbench for tile_work_dispatcher: directed and random
// transfers checked against an in-bench table predictor. Depends on tdisp_pkg.
`timescale 1ns / 1ps

module tile_work_dispatcher_tb;

  localparam int LIMIT = 1_500_000;
  localparam int SETTLE = 2 * tdisp_pkg::MAX_TILES_DEF + 16;
  localparam logic [tdisp_pkg::ACT_W-1:0] ACT_TOP = '1;
  localparam logic signed [tdisp_pkg::INDEX_W-1:0] IDX_MIN = 7'sh40;

  typedef struct packed {
    logic signed [tdisp_pkg::INDEX_W-1:0] tile;
    logic                                 done;
  } grant_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_we = 1'b0;
  logic [tdisp_pkg::COUNT_W-1:0]        cfg_wdata = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [tdisp_pkg::ACT_W-1:0]          action = tdisp_pkg::ACT_REQUEST;
  logic signed [tdisp_pkg::INDEX_W-1:0] tile_index = tdisp_pkg::NO_TILE;
  logic [tdisp_pkg::PASS_W-1:0]         pass_number = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [tdisp_pkg::INDEX_W-1:0] next_tile;
  logic                                 all_done;

  tile_work_dispatcher u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .tile_index (tile_index),
    .pass_number(pass_number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .next_tile  (next_tile),
    .all_done   (all_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted tile table
  bit                            tile_on   [tdisp_pkg::MAX_TILES_DEF];
  logic [tdisp_pkg::PASS_W-1:0]  resv_pass [tdisp_pkg::MAX_TILES_DEF];
  logic [tdisp_pkg::PASS_W-1:0]  done_at   [tdisp_pkg::MAX_TILES_DEF];
  logic [tdisp_pkg::COUNT_W-1:0] count_m = tdisp_pkg::TILE_COUNT_RESET;

  grant_t pending_grants[$];
  int     mismatches = 0;
  int     items_sent = 0;
  int     results_seen = 0;
  int     settings_used = 0;
  int     cycles = 0;
  int     stall_left = 0;
  bit     quiet = 1'b0;

  function automatic grant_t dispatch_predict(logic [tdisp_pkg::ACT_W-1:0] act,
                                              logic signed [tdisp_pkg::INDEX_W-1:0] idx,
                                              logic [tdisp_pkg::PASS_W-1:0] pass);
    grant_t g;
    int si;
    int n;
    int first;
    si = idx;
    n = (count_m > tdisp_pkg::MAX_TILES_DEF) ? tdisp_pkg::MAX_TILES_DEF : int'(count_m);
    g.tile = tdisp_pkg::NO_TILE;
    g.done = 1'b1;
    case (act)
      tdisp_pkg::ACT_REQUEST: begin
        first = 0;
        if (si >= 0) begin
          if (si < n) done_at[si] = pass;
          first = si + 1;
        end
        for (int i = first; i < n; i++) begin
          if (tile_on[i] && resv_pass[i] < pass) begin
            resv_pass[i] = pass;
            g.tile = 7'(i);
            break;
          end
        end
      end
      tdisp_pkg::ACT_DISABLE: begin
        if (si >= 0 && si < n) tile_on[si] = 1'b0;
      end
      tdisp_pkg::ACT_RESERVE: begin
        if (si >= 0 && si < n) resv_pass[si] = 16'd1;
      end
      tdisp_pkg::ACT_ENABLE_ALL: begin
        foreach (tile_on[i]) tile_on[i] = 1'b1;
      end
      tdisp_pkg::ACT_CLEAR: begin
        foreach (resv_pass[i]) begin
          resv_pass[i] = '0;
          done_at[i] = '0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      if (done_at[i] < pass) g.done = 1'b0;
    end
    return g;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_item(input logic [tdisp_pkg::ACT_W-1:0] act,
                           input logic signed [tdisp_pkg::INDEX_W-1:0] idx,
                           input logic [tdisp_pkg::PASS_W-1:0] pass, output grant_t g);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    tile_index <= idx;
    pass_number <= pass;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = dispatch_predict(act, idx, pass);
    pending_grants.push_back(g);
    items_sent++;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_tile_count(input logic [tdisp_pkg::COUNT_W-1:0] v);
    drain_and_settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_m = v;
    settings_used++;
  endtask

  task automatic test_reset_state();
    grant_t g;
    send_item(tdisp_pkg::ACT_REQUEST, tdisp_pkg::NO_TILE, 16'd0, g);
    send_item(tdisp_pkg::ACT_REQUEST, tdisp_pkg::NO_TILE, 16'd1, g);
  endtask

  task automatic test_actions();
    grant_t g;
    send_item(tdisp_pkg::ACT_REQUEST, 7'sd0, 16'd1, g);
    send_item(tdisp_pkg::ACT_DISABLE, 7'sd2, 16'd1, g);
    send_item(tdisp_pkg::ACT_RESERVE, 7'sd3, 16'd1, g);
    send_item(tdisp_pkg::ACT_REQUEST, 7'sd1, 16'd1, g);
    send_item(tdisp_pkg::ACT_DISABLE, tdisp_pkg::NO_TILE, 16'd1, g);
    send_item(tdisp_pkg::ACT_RESERVE, 7'sd63, 16'd2, g);
    send_item(tdisp_pkg::ACT_ENABLE_ALL, 7'sd0, 16'd1, g);
    for (int a = tdisp_pkg::ACT_CLEAR + 1; a <= ACT_TOP; a++) begin
      send_item(3'(a), 7'sd5, 16'hFFFF, g);
    end
    send_item(tdisp_pkg::ACT_REQUEST, 7'sd63, 16'hFFFF, g);
    send_item(tdisp_pkg::ACT_REQUEST, IDX_MIN, 16'hFFFF, g);
    send_item(tdisp_pkg::ACT_CLEAR, 7'sd0, 16'h0000, g);
    send_item(tdisp_pkg::ACT_REQUEST, tdisp_pkg::NO_TILE, 16'h8000, g);
  endtask

  task automatic test_count_extremes();
    grant_t g;
    set_tile_count(7'd1);
    send_item(tdisp_pkg::ACT_REQUEST, tdisp_pkg::NO_TILE, 16'd2, g);
    send_item(tdisp_pkg::ACT_REQUEST, 7'sd0, 16'd2, g);
    send_item(tdisp_pkg::ACT_REQUEST, 7'sd5, 16'd3, g);
    send_item(tdisp_pkg::ACT_DISABLE, 7'sd1, 16'd3, g);
    set_tile_count(7'd0);
    send_item(tdisp_pkg::ACT_REQUEST, tdisp_pkg::NO_TILE, 16'd1, g);
    set_tile_count(7'd127);
    send_item(tdisp_pkg::ACT_REQUEST, tdisp_pkg::NO_TILE, 16'hFFFF, g);
  endtask

  // one render pass: chain requests, each finishing the tile handed out last
  task automatic run_render_pass(input logic [tdisp_pkg::PASS_W-1:0] pass,
                                 inout int budget);
    grant_t g;
    grant_t side;
    logic signed [tdisp_pkg::INDEX_W-1:0] fin;
    fin = tdisp_pkg::NO_TILE;
    if ($urandom_range(0, 19) == 0) begin
      send_item(tdisp_pkg::ACT_ENABLE_ALL, 7'($urandom), pass, side);
    end
    if ($urandom_range(0, 19) == 0) begin
      send_item(tdisp_pkg::ACT_CLEAR, 7'($urandom), pass, side);
    end
    do begin
      if ($urandom_range(0, 9) == 0) begin
        send_item($urandom_range(0, 1) ? tdisp_pkg::ACT_DISABLE : tdisp_pkg::ACT_RESERVE,
                  7'($urandom_range(0, 64)), pass, side);
        budget--;
      end
      send_item(tdisp_pkg::ACT_REQUEST, fin, pass, g);
      budget--;
      fin = g.tile;
    end while (g.tile != tdisp_pkg::NO_TILE && budget > 0);
  endtask

  task automatic test_random_phases();
    grant_t g;
    logic [tdisp_pkg::COUNT_W-1:0] counts [8];
    logic [tdisp_pkg::PASS_W-1:0] pass_cur;
    logic [tdisp_pkg::ACT_W-1:0] act;
    int budget;
    counts = '{7'($urandom_range(2, 12)), 7'd64, 7'($urandom_range(1, 20)), 7'd127,
               7'($urandom_range(0, 8)), 7'($urandom_range(1, 64)), 7'd1,
               7'($urandom_range(2, 16))};
    pass_cur = 16'($urandom_range(1, 100));
    for (int ph = 0; ph < 8; ph++) begin
      set_tile_count(counts[ph]);
      quiet = (ph == 3 || ph == 6);
      budget = 105;
      while (budget > 0) begin
        if ($urandom_range(0, 99) < 70) begin
          case ($urandom_range(0, 9))
            0: ;
            1: pass_cur = 16'($urandom);
            default: pass_cur = pass_cur + 16'($urandom_range(1, 2));
          endcase
          run_render_pass(pass_cur, budget);
        end else begin
          act = 3'($urandom);
          send_item(act, 7'($urandom), 16'($urandom), g);
          if (act <= tdisp_pkg::ACT_CLEAR) budget--;
        end
      end
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    grant_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_grants.size() == 0) begin
        if (mismatches < 10)
          $display("cycle %0d: unexpected result next_tile=%0d all_done=%0b",
                   cycles, next_tile, all_done);
        mismatches++;
      end else begin
        e = pending_grants.pop_front();
        if (next_tile !== e.tile || all_done !== e.done) begin
          if (mismatches < 10)
            $display("cycle %0d: exp tile=%0d done=%0b, got tile=%0d done=%0b",
                     cycles, e.tile, e.done, next_tile, all_done);
          mismatches++;
        end
      end
    end
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_grants.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    foreach (tile_on[i]) begin
      tile_on[i] = 1'b1;
      resv_pass[i] = '0;
      done_at[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    test_reset_state();
    test_actions();
    test_count_extremes();
    test_random_phases();
    drain_and_settle();
    $display("Covered %0d input transfers, %0d results checked, %0d tile-count settings,",
             items_sent, results_seen, settings_used);
    $display("all actions incl. unknown codes, render passes, noise; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
